@@ rtl/dtcp_pkg.sv @@
// shared constants, codes and types for the depth to color point cloud block
package dtcp_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int DIV_STEPS = 32;
  localparam int PROJ_LAT  = DIV_STEPS + 3;

  localparam logic [2:0] CFG_NEAR   = 3'd0;
  localparam logic [2:0] CFG_FAR    = 3'd1;
  localparam logic [2:0] CFG_EXTENT = 3'd2;
  localparam logic [2:0] CFG_FX     = 3'd3;
  localparam logic [2:0] CFG_FY     = 3'd4;
  localparam logic [2:0] CFG_CX     = 3'd5;
  localparam logic [2:0] CFG_CY     = 3'd6;

  typedef struct packed {
    logic        v;
    logic [11:0] col;
    logic [11:0] row;
    logic [23:0] rgb;
  } pix_side_t;

  typedef struct packed {
    logic        v;
    logic        keep;
    logic [31:0] z;
    logic [23:0] rgb;
  } pt_side_t;

  typedef struct packed {
    logic en;
    logic keep;
  } proj_ctl_t;

endpackage

@@ rtl/depth_to_color_point_cloud.sv @@
// Turns one depth-and-color pixel per clock into a point-cloud point. A pixel is
// taken every cycle while the pipeline moves; the point passes the input register,
// two front stages, 33 stages of the 32-step restoring divider for depth, one select
// stage, 35 stages of projection with its own 32-step divider, and the output
// register. The input skid register holds one pixel, keeping the input open for one
// more pixel while the output is stalled. The user must write registers only while
// no pixel is in flight; the block itself does not enforce this.
module depth_to_color_point_cloud (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_column,
  input  logic [11:0] in_row,
  input  logic [23:0] in_depth_sample,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_point_valid,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic [23:0] out_packed_rgb
);
  import dtcp_pkg::*;

  localparam logic [12:0] DIM_LIMIT = 13'(MAX_DIM);

  logic [23:0] near_r, far_r, ext_r, fx_r, fy_r;
  logic [11:0] cx_r, cy_r;

  logic        en;
  logic        skid_full_r;
  pix_side_t   skid_r;
  logic [23:0] skid_d_r;
  pix_side_t   in_side;

  pix_side_t   sd0_r, sd1_r, sd2_r;
  logic [23:0] d0_r;
  logic        fge;
  logic [23:0] diff;
  logic        fge_r;
  logic [47:0] pd_r, pnf_r;
  logic [48:0] base;
  logic [48:0] den2_r;
  logic [47:0] hi_r, lo_r;
  logic [79:0] numer;

  pix_side_t   dsd_r  [0:DIV_STEPS];
  logic [48:0] drem_r [0:DIV_STEPS];
  logic [31:0] dlow_r [0:DIV_STEPS];
  logic [31:0] dq_r   [0:DIV_STEPS];
  logic [48:0] dden_r [0:DIV_STEPS];
  logic        dover_r[0:DIV_STEPS];
  logic [49:0] dtrial [0:DIV_STEPS-1];
  logic        dge    [0:DIV_STEPS-1];

  logic [31:0] zsel;
  logic        vsel;
  pix_side_t   zsd_r;
  logic [31:0] z_r;
  logic        vpt_r;

  pt_side_t    tl_r [0:PROJ_LAT-1];
  proj_ctl_t   pctl;
  logic [31:0] px, py;

  logic        out_valid_r, out_pv_r;
  logic [31:0] out_x_r, out_y_r, out_z_r;
  logic [23:0] out_rgb_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = skid_full_r;
  assign in_side  = '{v: in_valid, col: in_column, row: in_row,
                      rgb: {in_red, in_green, in_blue}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 24'd65;
      far_r  <= 24'd3276800;
      ext_r  <= 24'd65536;
      fx_r   <= 24'd131072;
      fy_r   <= 24'd131072;
      cx_r   <= 12'd320;
      cy_r   <= 12'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEAR:   near_r <= cfg_data;
        CFG_FAR:    far_r  <= cfg_data;
        CFG_EXTENT: ext_r  <= cfg_data;
        CFG_FX:     fx_r   <= cfg_data;
        CFG_FY:     fy_r   <= cfg_data;
        CFG_CX:     cx_r   <= cfg_data[11:0];
        CFG_CY:     cy_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign fge  = far_r >= near_r;
  assign diff = fge ? (far_r - near_r) : (near_r - far_r);
  assign base = {1'b0, far_r, 24'b0};
  assign numer = {hi_r, 32'b0} + {24'b0, lo_r, 8'b0};

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dtrial[k] = {drem_r[k], dlow_r[k][31]};
      dge[k]    = dtrial[k] >= {1'b0, dden_r[k]};
    end
  end

  assign zsel = dover_r[DIV_STEPS] ? 32'hFFFF_FFFF : dq_r[DIV_STEPS];
  assign vsel = (dden_r[DIV_STEPS] != '0) && (zsel < {8'b0, far_r})
             && ({1'b0, dsd_r[DIV_STEPS].col} < DIM_LIMIT)
             && ({1'b0, dsd_r[DIV_STEPS].row} < DIM_LIMIT);

  // control: skid, valid bits and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
      sd0_r       <= '0;
      sd1_r       <= '0;
      sd2_r       <= '0;
      zsd_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dsd_r[k] <= '0;
      for (int k = 0; k < PROJ_LAT; k++) tl_r[k] <= '0;
    end else begin
      if (en) begin
        skid_full_r <= 1'b0;
        sd0_r       <= skid_full_r ? skid_r : in_side;
        sd1_r       <= sd0_r;
        sd2_r       <= sd1_r;
        dsd_r[0]    <= sd2_r;
        for (int k = 0; k < DIV_STEPS; k++) dsd_r[k+1] <= dsd_r[k];
        zsd_r       <= dsd_r[DIV_STEPS];
        tl_r[0]     <= '{v: zsd_r.v, keep: vpt_r, z: z_r, rgb: zsd_r.rgb};
        for (int k = 0; k < PROJ_LAT - 1; k++) tl_r[k+1] <= tl_r[k];
        out_valid_r <= tl_r[PROJ_LAT-1].v;
      end else if (in_valid && !skid_full_r) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_full_r) begin
      skid_r   <= in_side;
      skid_d_r <= in_depth_sample;
    end
    if (en) begin
      d0_r   <= skid_full_r ? skid_d_r : in_depth_sample;
      fge_r  <= fge;
      pd_r   <= {24'b0, diff} * {24'b0, d0_r};
      pnf_r  <= {24'b0, near_r} * {24'b0, far_r};
      den2_r <= fge_r ? (base - {1'b0, pd_r}) : (base + {1'b0, pd_r});
      hi_r   <= {24'b0, pnf_r[47:24]} * {24'b0, ext_r};
      lo_r   <= {24'b0, pnf_r[23:0]} * {24'b0, ext_r};
      drem_r[0]  <= {1'b0, numer[79:32]};
      dlow_r[0]  <= numer[31:0];
      dq_r[0]    <= '0;
      dden_r[0]  <= den2_r;
      dover_r[0] <= {1'b0, numer[79:32]} >= den2_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        drem_r[k+1]  <= dge[k] ? 49'(dtrial[k] - {1'b0, dden_r[k]}) : dtrial[k][48:0];
        dlow_r[k+1]  <= {dlow_r[k][30:0], 1'b0};
        dq_r[k+1]    <= {dq_r[k][30:0], dge[k]};
        dden_r[k+1]  <= dden_r[k];
        dover_r[k+1] <= dover_r[k];
      end
      z_r       <= zsel;
      vpt_r     <= vsel;
      out_pv_r  <= tl_r[PROJ_LAT-1].keep;
      out_x_r   <= px;
      out_y_r   <= py;
      out_z_r   <= tl_r[PROJ_LAT-1].z;
      out_rgb_r <= tl_r[PROJ_LAT-1].rgb;
    end
  end

  assign pctl = '{en: en, keep: vpt_r};

  dtcp_proj u_proj_x (
    .clk   (clk),
    .ctl   (pctl),
    .pix   (zsd_r.col),
    .ctr   (cx_r),
    .focal (fx_r),
    .z     (z_r),
    .coord (px)
  );

  dtcp_proj u_proj_y (
    .clk   (clk),
    .ctl   (pctl),
    .pix   (zsd_r.row),
    .ctr   (cy_r),
    .focal (fy_r),
    .z     (z_r),
    .coord (py)
  );

  assign out_valid       = out_valid_r;
  assign out_point_valid = out_pv_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_z     = out_z_r;
  assign out_packed_rgb  = out_rgb_r;

`ifndef SYNTH
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(!en))
    else $error("skid filled while pipeline moved");

  a_invalid_zero_xy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pv_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("invalid point carries nonzero coordinates");

  a_valid_below_far: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pv_r) |-> (out_z_r < {8'b0, far_r}))
    else $error("valid point at or beyond far plane");
`endif

endmodule

@@ rtl/dtcp_proj.sv @@
// pipelined back-projection of one axis: (pix - ctr) * z * 2^8 / focal, saturated, zero when not kept
module dtcp_proj (
  input  logic               clk,
  input  dtcp_pkg::proj_ctl_t ctl,
  input  logic [11:0]        pix,
  input  logic [11:0]        ctr,
  input  logic [23:0]        focal,
  input  logic [31:0]        z,
  output logic [31:0]        coord
);
  import dtcp_pkg::*;

  logic        neg;
  logic [11:0] mag;
  logic [43:0] prod_nxt;
  logic [43:0] prod_r;
  logic        neg_r;
  logic        keep_r;

  logic [23:0] rem_r  [0:DIV_STEPS];
  logic [31:0] low_r  [0:DIV_STEPS];
  logic [31:0] q_r    [0:DIV_STEPS];
  logic        neg_a  [0:DIV_STEPS];
  logic        keep_a [0:DIV_STEPS];
  logic        over_a [0:DIV_STEPS];
  logic        nz_a   [0:DIV_STEPS];

  logic [23:0] rem_nxt [0:DIV_STEPS];
  logic [31:0] low_nxt [0:DIV_STEPS];
  logic [31:0] q_nxt   [0:DIV_STEPS];
  logic [24:0] trial   [0:DIV_STEPS-1];
  logic        ge      [0:DIV_STEPS-1];

  logic        ovf;
  logic [31:0] qf;
  logic [31:0] nmag;
  logic [31:0] coord_nxt;
  logic [31:0] coord_r;

  assign neg      = pix < ctr;
  assign mag      = neg ? (ctr - pix) : (pix - ctr);
  assign prod_nxt = {32'b0, mag} * {12'b0, z};

  always_comb begin
    rem_nxt[0] = {4'b0, prod_r[43:24]};
    low_nxt[0] = {prod_r[23:0], 8'b0};
    q_nxt[0]   = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k]     = {rem_r[k], low_r[k][31]};
      ge[k]        = trial[k] >= {1'b0, focal};
      rem_nxt[k+1] = ge[k] ? 24'(trial[k] - {1'b0, focal}) : trial[k][23:0];
      low_nxt[k+1] = {low_r[k][30:0], 1'b0};
      q_nxt[k+1]   = {q_r[k][30:0], ge[k]};
    end
  end

  // quotient overflow only counts when the numerator is nonzero
  assign ovf  = over_a[DIV_STEPS] && nz_a[DIV_STEPS];
  assign qf   = q_r[DIV_STEPS];
  assign nmag = (ovf || qf > 32'h8000_0000) ? 32'h8000_0000 : qf;

  always_comb begin
    if (!keep_a[DIV_STEPS] || !nz_a[DIV_STEPS]) begin
      coord_nxt = '0;
    end else if (neg_a[DIV_STEPS]) begin
      coord_nxt = 32'h0 - nmag;
    end else begin
      coord_nxt = (ovf || qf > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qf;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r    <= prod_nxt;
      neg_r     <= neg;
      keep_r    <= ctl.keep;
      rem_r[0]  <= rem_nxt[0];
      low_r[0]  <= low_nxt[0];
      q_r[0]    <= q_nxt[0];
      neg_a[0]  <= neg_r;
      keep_a[0] <= keep_r;
      over_a[0] <= {4'b0, prod_r[43:24]} >= focal;
      nz_a[0]   <= |prod_r;
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_r[k+1]  <= rem_nxt[k+1];
        low_r[k+1]  <= low_nxt[k+1];
        q_r[k+1]    <= q_nxt[k+1];
        neg_a[k+1]  <= neg_a[k];
        keep_a[k+1] <= keep_a[k];
        over_a[k+1] <= over_a[k];
        nz_a[k+1]   <= nz_a[k];
      end
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

@@ test/tb_depth_to_color_point_cloud.sv @@
// testbench for the depth to color point cloud block: predicts each point and checks it
`timescale 1ns / 100ps

module tb_depth_to_color_point_cloud;
  import dtcp_pkg::*;

  typedef struct {
    logic        valid;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [23:0] rgb;
  } point_t;

  class point_scoreboard;
    logic [23:0] near_q, far_q, extent_q, fx_q, fy_q;
    logic [11:0] cx_q, cy_q;
    point_t      pending[$];
    int          errors;
    int          checked;
    int          valid_seen;

    function new();
      near_q = 24'd65;
      far_q = 24'd3276800;
      extent_q = 24'd65536;
      fx_q = 24'd131072;
      fy_q = 24'd131072;
      cx_q = 12'd320;
      cy_q = 12'd240;
      errors = 0;
      checked = 0;
      valid_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        CFG_NEAR:   near_q = val;
        CFG_FAR:    far_q = val;
        CFG_EXTENT: extent_q = val;
        CFG_FX:     fx_q = val;
        CFG_FY:     fy_q = val;
        CFG_CX:     cx_q = val[11:0];
        CFG_CY:     cy_q = val[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] coord(logic [11:0] pix, logic [11:0] ctr, logic [31:0] z,
                                logic [23:0] f);
      logic        neg;
      logic [63:0] mag, num, q;
      neg = pix < ctr;
      mag = neg ? 64'(ctr - pix) : 64'(pix - ctr);
      num = (mag * 64'(z)) << 8;
      if (f == 0) q = (num == 0) ? 64'd0 : 64'hFF_FFFF_FFFF;
      else q = num / 64'(f);
      if (!neg) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'd0 - q[31:0];
    endfunction

    function void note_pixel(logic [11:0] c, logic [11:0] r, logic [23:0] d,
                             logic [7:0] re, logic [7:0] gr, logic [7:0] bl);
      point_t       p;
      logic [127:0] den, num, q;
      if (far_q >= near_q) den = (128'(far_q) << 24) - 128'(d) * 128'(far_q - near_q);
      else den = (128'(far_q) << 24) + 128'(d) * 128'(near_q - far_q);
      p.x = 0;
      p.y = 0;
      if (den == 0) begin
        p.z = 32'hFFFF_FFFF;
        p.valid = 0;
      end else begin
        num = (128'(near_q) * 128'(far_q) * 128'(extent_q)) << 8;
        q = num / den;
        p.z = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        p.valid = p.z < 32'(far_q);
      end
      if (p.valid) begin
        p.x = coord(c, cx_q, p.z, fx_q);
        p.y = coord(r, cy_q, p.z, fy_q);
      end
      p.rgb = {re, gr, bl};
      pending.push_back(p);
    endfunction

    function void check_point(logic v, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [23:0] rgb);
      point_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected point");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v) valid_seen++;
      if (v !== e.valid) begin
        $error("point_valid exp %0d got %0d", e.valid, v); errors++;
      end
      if (x !== e.x) begin
        $error("point_x exp %h got %h", e.x, x); errors++;
      end
      if (y !== e.y) begin
        $error("point_y exp %h got %h", e.y, y); errors++;
      end
      if (z !== e.z) begin
        $error("point_z exp %h got %h", e.z, z); errors++;
      end
      if (rgb !== e.rgb) begin
        $error("packed_rgb exp %h got %h", e.rgb, rgb); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid, in_stall;
  logic [11:0] in_column, in_row;
  logic [23:0] in_depth_sample;
  logic [7:0]  in_red, in_green, in_blue;
  logic        out_valid, out_stall;
  logic        out_point_valid;
  logic [31:0] out_point_x, out_point_y, out_point_z;
  logic [23:0] out_packed_rgb;

  point_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  hold_recv;
  int  hold_cycles;
  longint cycle_count;

  depth_to_color_point_cloud i_dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_point(out_point_valid, out_point_x, out_point_y, out_point_z,
                       out_packed_rgb);
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1;
      end else if (hold_recv) begin
        hold_cycles <= 300;
        hold_recv <= 0;
        out_stall <= 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [23:0] d,
                            logic [7:0] re, logic [7:0] gr, logic [7:0] bl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_column <= c;
    in_row <= r;
    in_depth_sample <= d;
    in_red <= re;
    in_green <= gr;
    in_blue <= bl;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(c, r, d, re, gr, bl);
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_depth();
    case ($urandom_range(5))
      0: return 24'hFFFFFF - 24'($urandom_range(255));
      1: return 24'($urandom_range(255));
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_pixels(int n);
    for (int i = 0; i < n; i++) begin
      send_pixel(12'($urandom()), 12'($urandom()), rand_depth(),
                 8'($urandom()), 8'($urandom()), 8'($urandom()));
    end
    end_burst();
  endtask

  task automatic random_config();
    write_reg(CFG_NEAR, ($urandom_range(3) == 0) ? 24'($urandom())
                                                 : 24'($urandom_range(65536)));
    write_reg(CFG_FAR, ($urandom_range(3) == 0) ? 24'($urandom())
                                                : 24'($urandom_range(16777215, 65536)));
    write_reg(CFG_EXTENT, ($urandom_range(1) == 0) ? 24'($urandom()) : 24'd65536);
    write_reg(CFG_FX, 24'($urandom_range(16777215, 1)));
    write_reg(CFG_FY, 24'($urandom_range(16777215, 1)));
    write_reg(CFG_CX, 24'($urandom()));
    write_reg(CFG_CY, 24'($urandom()));
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_column = 0; in_row = 0; in_depth_sample = 0;
    in_red = 0; in_green = 0; in_blue = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_recv = 0; hold_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes at reset settings
    send_pixel(0, 0, 0, 0, 0, 0);
    send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(320, 240, 24'h800000, 8'hA5, 8'h5A, 8'h0F);
    send_pixel(0, 12'hFFF, 24'hFFFF00, 8'h01, 8'h80, 8'hFE);
    send_pixel(12'hFFF, 0, 24'h000100, 8'h55, 8'hAA, 8'h33);
    end_burst();
    drain();

    // far equal to zero: zero denominator at zero depth
    write_reg(CFG_FAR, 0);
    send_pixel(10, 20, 0, 1, 2, 3);
    send_pixel(10, 20, 24'h123456, 1, 2, 3);
    end_burst();
    drain();

    // near above far, zero focal lengths, extreme centers
    write_reg(CFG_NEAR, 24'hFFFFFF);
    write_reg(CFG_FAR, 24'h000100);
    write_reg(CFG_EXTENT, 24'hFFFFFF);
    write_reg(CFG_FX, 0);
    write_reg(CFG_FY, 0);
    write_reg(CFG_CX, 12'hFFF);
    write_reg(CFG_CY, 0);
    send_pixel(0, 0, 0, 9, 9, 9);
    send_pixel(12'hFFF, 12'hFFF, 24'hFFFFFF, 9, 9, 9);
    end_burst();
    drain();

    // far maximal, small near: valid points with zero focal saturating
    write_reg(CFG_NEAR, 24'h010000);
    write_reg(CFG_FAR, 24'hFFFFFF);
    write_reg(CFG_EXTENT, 24'h010000);
    write_reg(CFG_CX, 2048);
    write_reg(CFG_CY, 2048);
    send_pixel(0, 12'hFFF, 24'h400000, 1, 1, 1);
    send_pixel(2048, 2048, 24'h400000, 1, 1, 1);
    send_pixel(12'hFFF, 0, 24'hFFF000, 1, 1, 1);
    end_burst();
    drain();

    // x focal minimal to force coordinate saturation, y focal maximal
    write_reg(CFG_FX, 1);
    write_reg(CFG_FY, 24'hFFFFFF);
    write_reg(CFG_EXTENT, 0);
    send_pixel(0, 0, 24'h400000, 2, 2, 2);
    end_burst();
    drain();
    write_reg(CFG_EXTENT, 24'h010000);
    send_pixel(0, 12'hFFF, 24'h400000, 2, 2, 2);
    send_pixel(12'hFFF, 0, 24'hFF0000, 2, 2, 2);
    end_burst();
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 31; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph > 0) random_config();
      if (ph == 2) hold_recv = 1;
      random_pixels(150);
      drain();
    end

    $display("covered %0d points, %0d valid, nine register settings plus directed corners",
             sb.checked, sb.valid_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
